// ===== hw/rtl/ps2s1_pkg.sv =====
package ps2s1_pkg;

	localparam int MAP_ENTRIES_DEF = 128;
	localparam int ADDR_W          = 8;
	localparam int CHAR_W          = 8;
	localparam int KEY_W           = 16;
	localparam int IDX_W           = 7;
	localparam int REG_IDX_W       = 3;

	localparam logic [7:0] SC_PREFIX      = 8'hE0;
	localparam logic [7:0] SC_LSHIFT_MAKE = 8'h2A;
	localparam logic [7:0] SC_RSHIFT_MAKE = 8'h36;
	localparam logic [7:0] SC_CTRL_MAKE   = 8'h1D;
	localparam logic [7:0] SC_LSHIFT_BRK  = 8'hAA;
	localparam logic [7:0] SC_RSHIFT_BRK  = 8'hB6;
	localparam logic [7:0] SC_CTRL_BRK    = 8'h9D;
	localparam logic [7:0] SC_UP          = 8'h48;
	localparam logic [7:0] SC_DOWN        = 8'h50;
	localparam logic [7:0] SC_LEFT        = 8'h4B;
	localparam logic [7:0] SC_RIGHT       = 8'h4D;
	localparam logic [7:0] SC_DELETE      = 8'h53;

	localparam logic [REG_IDX_W-1:0] REG_ENABLE = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_UP     = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_DOWN   = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_LEFT   = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_RIGHT  = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_DELETE = 3'd5;

	localparam logic [KEY_W-1:0] UP_RST     = 16'd256;
	localparam logic [KEY_W-1:0] DOWN_RST   = 16'd257;
	localparam logic [KEY_W-1:0] LEFT_RST   = 16'd258;
	localparam logic [KEY_W-1:0] RIGHT_RST  = 16'd259;
	localparam logic [KEY_W-1:0] DELETE_RST = 16'd260;

	localparam logic [CHAR_W-1:0] CH_UPPER_A = 8'h41;
	localparam logic [CHAR_W-1:0] CH_UPPER_Z = 8'h5A;
	localparam logic [CHAR_W-1:0] CH_LOWER_A = 8'h61;
	localparam logic [CHAR_W-1:0] CH_LOWER_Z = 8'h7A;
	localparam logic [CHAR_W-1:0] CH_CASE    = 8'h20;
	localparam logic [CHAR_W-1:0] CH_CTRL    = 8'h60;

	typedef struct packed {
		logic              we;
		logic              re;
		logic              sel;
		logic [IDX_W-1:0]  index;
		logic [CHAR_W-1:0] wdata;
	} km_req_t;

	function automatic logic [CHAR_W-1:0] fold_ctrl(input logic [CHAR_W-1:0] ch,
		input logic ctrl);
		logic [CHAR_W-1:0] low;
		low = ch;
		if (!ctrl) begin
			return ch;
		end
		if (low >= CH_UPPER_A && low <= CH_UPPER_Z) begin
			low = low + CH_CASE;
		end
		if (low >= CH_LOWER_A && low <= CH_LOWER_Z) begin
			return low - CH_CTRL;
		end
		return ch;
	endfunction

endpackage

// ===== hw/rtl/ps2s1_keymap.sv =====
module ps2s1_keymap #(
	parameter int MAP_ENTRIES = ps2s1_pkg::MAP_ENTRIES_DEF
) (
	input  logic                       clk,
	input  ps2s1_pkg::km_req_t         req,
	output logic [ps2s1_pkg::CHAR_W-1:0] rdata
);
	import ps2s1_pkg::*;

	logic [CHAR_W-1:0] mem [1 << ADDR_W];
	logic [ADDR_W:0]   sum;
	logic [ADDR_W-1:0] addr;
	logic [CHAR_W-1:0] rdata_q;

	// plain map from 0, shifted map from MAP_ENTRIES, wrapping at the store size
	assign sum  = (req.sel ? (ADDR_W+1)'(MAP_ENTRIES) : '0) + (ADDR_W+1)'(req.index);
	assign addr = sum[ADDR_W-1:0];

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[addr] <= req.wdata;
		end
		if (req.re) begin
			rdata_q <= mem[addr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== hw/rtl/ps2_set1_scancode_decoder_top.sv =====
// Channel   Dir  tdata (low bit up)                                    tuser
// s_axis    in   scan_byte[7:0] map_select[8] map_index[15:9]         command
//                map_char[23:16]
// m_axis    out  key_code[15:0]                                        -
// wr_*      in   wr_index selects register, wr_data[15:0]              -
//
// One request per cycle while s_axis_tready is high. A key code reaches m_axis
// via stage one (the keymap read), the ctrl fold and zero check, and out_data_q.
// Reset clears the held flags, the pipeline and the registers; the keymap is
// not cleared and holds nothing until loaded.
// A stalled result holds in the output register; the stage behind it holds
// the next lookup and s_axis_tready drops only when both are full.
module ps2_set1_scancode_decoder_top #(
	parameter int MAP_ENTRIES = ps2s1_pkg::MAP_ENTRIES_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	// scan_byte[7:0], map_select[8], map_index[15:9], map_char[23:16]
	input  logic [23:0]                      s_axis_tdata,
	// command[0]
	input  logic                             s_axis_tuser,
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	// key_code[15:0]
	output logic [ps2s1_pkg::KEY_W-1:0]      m_axis_tdata,
	input  logic                             wr_en,
	input  logic [ps2s1_pkg::REG_IDX_W-1:0]  wr_index,
	input  logic [ps2s1_pkg::KEY_W-1:0]      wr_data
);
	import ps2s1_pkg::*;

	logic              enable_q;
	logic [KEY_W-1:0]  up_q, down_q, left_q, right_q, delete_q;
	logic              prefix_q, shift_q, ctrl_q;

	logic [7:0]        scan;
	logic              accept, decode;
	logic              advance;
	km_req_t           req;
	logic [CHAR_W-1:0] rdata;

	logic              cand, cand_ext;
	logic [KEY_W-1:0]  ext_code;
	logic              prefix_d, shift_d, ctrl_d;

	logic              valid_s1, ext_s1, ctrl_s1;
	logic [KEY_W-1:0]  code_s1;
	logic [KEY_W-1:0]  key_s1;

	logic              out_valid_q;
	logic [KEY_W-1:0]  out_data_q;

	assign scan    = s_axis_tdata[7:0];
	assign advance = !out_valid_q || m_axis_tready;
	assign s_axis_tready = !valid_s1 || advance;
	assign accept  = s_axis_tvalid && s_axis_tready;
	assign decode  = accept && !s_axis_tuser && enable_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= 1'b0;
			up_q     <= UP_RST;
			down_q   <= DOWN_RST;
			left_q   <= LEFT_RST;
			right_q  <= RIGHT_RST;
			delete_q <= DELETE_RST;
		end else if (wr_en) begin
			case (wr_index)
				REG_ENABLE: enable_q <= wr_data[0];
				REG_UP:     up_q     <= wr_data;
				REG_DOWN:   down_q   <= wr_data;
				REG_LEFT:   left_q   <= wr_data;
				REG_RIGHT:  right_q  <= wr_data;
				REG_DELETE: delete_q <= wr_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (scan)
			SC_UP:     ext_code = up_q;
			SC_DOWN:   ext_code = down_q;
			SC_LEFT:   ext_code = left_q;
			SC_RIGHT:  ext_code = right_q;
			SC_DELETE: ext_code = delete_q;
			default:   ext_code = '0;
		endcase
	end

	always_comb begin
		prefix_d = prefix_q;
		shift_d  = shift_q;
		ctrl_d   = ctrl_q;
		cand     = 1'b0;
		cand_ext = 1'b0;
		if (scan == SC_PREFIX) begin
			prefix_d = 1'b1;
		end else if (prefix_q) begin
			prefix_d = 1'b0;
			cand     = !scan[7];
			cand_ext = 1'b1;
		end else begin
			case (scan) inside
				SC_LSHIFT_MAKE, SC_RSHIFT_MAKE: shift_d = 1'b1;
				SC_LSHIFT_BRK, SC_RSHIFT_BRK:   shift_d = 1'b0;
				SC_CTRL_MAKE:                   ctrl_d  = 1'b1;
				SC_CTRL_BRK:                    ctrl_d  = 1'b0;
				default:                        cand    = !scan[7] && scan != '0;
			endcase
		end
	end

	always_comb begin
		req       = '0;
		req.we    = accept && s_axis_tuser;
		req.re    = decode && cand && !cand_ext;
		req.wdata = s_axis_tdata[23:16];
		if (s_axis_tuser) begin
			req.sel   = s_axis_tdata[8];
			req.index = s_axis_tdata[15:9];
		end else begin
			req.sel   = shift_q;
			req.index = scan[IDX_W-1:0];
		end
	end

	ps2s1_keymap #(
		.MAP_ENTRIES(MAP_ENTRIES)
	) u_keymap (
		.clk  (clk),
		.req  (req),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prefix_q <= 1'b0;
			shift_q  <= 1'b0;
			ctrl_q   <= 1'b0;
		end else if (decode) begin
			prefix_q <= prefix_d;
			shift_q  <= shift_d;
			ctrl_q   <= ctrl_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= decode && cand;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (decode) begin
			ext_s1  <= cand_ext;
			ctrl_s1 <= ctrl_q;
			code_s1 <= ext_code;
		end
	end

	assign key_s1 = ext_s1 ? code_s1 : KEY_W'(fold_ctrl(rdata, ctrl_s1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1 && key_s1 != '0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_data_q <= key_s1;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && out_valid_q && !m_axis_tready |-> !s_axis_tready)
		else $error("request taken while both result stages are full");

	a_one_port: assert property (@(posedge clk) disable iff (!arst_n)
		!(req.we && req.re))
		else $error("keymap read and write in one cycle");

	a_read_lands: assert property (@(posedge clk) disable iff (!arst_n)
		req.re |=> valid_s1 && !ext_s1)
		else $error("keymap read without a lookup in stage one");

	a_flags_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!decode |=> $stable(shift_q) && $stable(ctrl_q) && $stable(prefix_q))
		else $error("held flags changed without a decoded request");

endmodule
